// File: sv/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Used by the front, queue, back and top-level modules.
package u2u_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [20:0] BOM_CP      = 21'h00FEFF;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;

  typedef struct packed {
    logic        two;
    logic [15:0] unit0;
    logic        bad0;
    logic [15:0] unit1;
    logic        bad1;
  } u2u_entry_t;

  typedef struct packed {
    logic       valid;
    u2u_entry_t entry;
  } u2u_head_t;

endpackage

// File: sv/utf8_to_utf16_decoder_core.sv
// UTF-8 to UTF-16 transcoder, top level.
// Connects u2u_front, u2u_queue and u2u_back; depends on u2u_pkg.
//
// Input channel: in_valid/in_ready carry one byte (data_byte) with first_byte
// marking the start of a text and last_byte its end. Output channel:
// out_valid/out_ready carry one UTF-16 code unit with bad_sequence set on a
// 0xFFFD error unit and last_of_run set on the final unit caused by a byte.
// A byte yields zero, one or two units (two for a surrogate pair, or for an
// error followed by another unit); a leading U+FEFF of a text is dropped.
// Throughput: one byte per cycle while out_ready stays high and each byte
// yields at most one unit; the output side moves one unit per cycle while
// out_ready is high. A byte's units are registered into the queue when it
// is accepted and are offered from its head. Between decoder and serializer
// sits a four-entry queue; in_ready stays high while it has room, so input
// keeps flowing with out_ready low until it fills, then stalls until drained.
// Reset (rst, synchronous) empties the queue, clears any open sequence and
// marks the stream as having emitted nothing yet.
module utf8_to_utf16_decoder_core
  import u2u_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        bad_sequence,
  output logic        last_of_run
);

  logic       push;
  logic       pop;
  logic       space;
  u2u_entry_t entry;
  u2u_head_t  head;

  u2u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .space      (space),
    .in_ready   (in_ready),
    .push       (push),
    .entry      (entry)
  );

  u2u_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .entry_in (entry),
    .pop      (pop),
    .space    (space),
    .head     (head)
  );

  u2u_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .code_unit    (code_unit),
    .bad_sequence (bad_sequence),
    .last_of_run  (last_of_run)
  );

endmodule

// File: sv/u2u_front.sv
// Front end: decodes one UTF-8 byte per cycle, while the queue has space, into zero to two UTF-16 units.
// Holds the sequence state; depends on u2u_pkg.
module u2u_front
  import u2u_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  input  logic       space,
  output logic       in_ready,
  output logic       push,
  output u2u_entry_t entry
);

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [20:0] accum, accum_next;
  logic        nothing_emitted, nothing_emitted_next;

  logic [1:0]  pend;
  logic [20:0] acc;
  logic        ne;
  logic        lead;
  logic [1:0]  n;
  logic [15:0] unit_v [2];
  logic        bad_v  [2];
  logic [20:0] cp;
  logic [19:0] sv_off;
  logic        accept;

  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pend      = first_byte ? 2'd0 : bytes_pending;
    acc       = first_byte ? 21'd0 : accum;
    ne        = first_byte | nothing_emitted;
    n         = 2'd0;
    unit_v[0] = '0;
    unit_v[1] = '0;
    bad_v[0]  = 1'b0;
    bad_v[1]  = 1'b0;
    lead      = 1'b0;
    cp        = {acc[14:0], data_byte[5:0]};
    sv_off    = 20'(cp - SUPP_BASE);
    bytes_pending_next = pend;
    accum_next         = acc;

    if (pend == 2'd0) begin
      lead = 1'b1;
    end else if (data_byte[7:6] == 2'b10) begin
      bytes_pending_next = pend - 2'd1;
      accum_next         = cp;
      if (pend == 2'd1) begin
        accum_next = '0;
        if (cp == BOM_CP && ne) begin
          n = 2'd0;
        end else if (cp < SUPP_BASE) begin
          unit_v[0] = cp[15:0];
          n         = 2'd1;
        end else if (cp <= CP_MAX) begin
          unit_v[0] = HI_SURR | {6'd0, sv_off[19:10]};
          unit_v[1] = LO_SURR | {6'd0, sv_off[9:0]};
          n         = 2'd2;
        end else begin
          unit_v[0] = REPLACEMENT;
          bad_v[0]  = 1'b1;
          n         = 2'd1;
        end
      end
    end else begin
      unit_v[0]          = REPLACEMENT;
      bad_v[0]           = 1'b1;
      n                  = 2'd1;
      bytes_pending_next = 2'd0;
      accum_next         = '0;
      lead               = 1'b1;
    end

    if (lead) begin
      if (!data_byte[7]) begin
        unit_v[n[0]] = {8'd0, data_byte};
        bad_v[n[0]]  = 1'b0;
        n            = n + 2'd1;
      end else if (data_byte[7:5] == 3'b110) begin
        bytes_pending_next = 2'd1;
        accum_next         = {16'd0, data_byte[4:0]};
      end else if (data_byte[7:4] == 4'b1110) begin
        bytes_pending_next = 2'd2;
        accum_next         = {17'd0, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110) begin
        bytes_pending_next = 2'd3;
        accum_next         = {18'd0, data_byte[2:0]};
      end else begin
        unit_v[n[0]] = REPLACEMENT;
        bad_v[n[0]]  = 1'b1;
        n            = n + 2'd1;
      end
    end

    if (last_byte && bytes_pending_next != 2'd0) begin
      unit_v[n[0]]       = REPLACEMENT;
      bad_v[n[0]]        = 1'b1;
      n                  = n + 2'd1;
      bytes_pending_next = 2'd0;
      accum_next         = '0;
    end

    nothing_emitted_next = ne && (n == 2'd0);
  end

  assign push        = accept && (n != 2'd0);
  assign entry.two   = (n == 2'd2);
  assign entry.unit0 = unit_v[0];
  assign entry.bad0  = bad_v[0];
  assign entry.unit1 = unit_v[1];
  assign entry.bad1  = bad_v[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= '0;
      accum           <= '0;
      nothing_emitted <= 1'b1;
    end else if (accept) begin
      bytes_pending   <= bytes_pending_next;
      accum           <= accum_next;
      nothing_emitted <= nothing_emitted_next;
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> bytes_pending == 2'd0)
    else $error("sequence still pending after last byte");
  a_push_marks: assert property (@(posedge clk) disable iff (rst)
    push |=> !nothing_emitted)
    else $error("emitted flag not cleared after output");
  a_idle_accum: assert property (@(posedge clk) disable iff (rst)
    bytes_pending == 2'd0 |-> accum == '0)
    else $error("accumulator holds bits with no sequence open");
`endif

endmodule

// File: sv/u2u_queue.sv
// Short request queue between the byte decoder and the output serializer.
// Depends on u2u_pkg for depth and entry type.
module u2u_queue
  import u2u_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  u2u_entry_t entry_in,
  input  logic       pop,
  output logic       space,
  output u2u_head_t  head
);

  u2u_entry_t       store [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign space      = count < QCntW'(QDepth);
  assign head.valid = count != '0;
  assign head.entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCntW'(1);
        2'b01:   count <= count - QCntW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("queue count out of range");
`endif

endmodule

// File: sv/u2u_back.sv
// Back end: walks each queued request out as one or two UTF-16 units.
// Depends on u2u_pkg for the request and head types.
module u2u_back
  import u2u_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  u2u_head_t   head,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [15:0] code_unit,
  output logic        bad_sequence,
  output logic        last_of_run
);

  logic second;
  logic take;

  assign out_valid    = head.valid;
  assign code_unit    = second ? head.entry.unit1 : head.entry.unit0;
  assign bad_sequence = second ? head.entry.bad1 : head.entry.bad0;
  assign last_of_run  = second || !head.entry.two;
  assign take         = out_valid && out_ready;
  assign pop          = take && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (take) begin
      second <= !last_of_run;
    end
  end

`ifndef SYNTHESIS
  a_second_valid: assert property (@(posedge clk) disable iff (rst)
    second |-> head.valid && head.entry.two)
    else $error("second unit selected without a pair at head");
  a_pop_taken: assert property (@(posedge clk) disable iff (rst)
    pop |-> out_valid && out_ready)
    else $error("request dropped without delivery");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    take && !last_of_run |=> second && out_valid)
    else $error("low surrogate lost after high surrogate");
`endif

endmodule
